// ----- rtl/core/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants, width helpers and types of the matrix to quaternion block
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int RMQ_DATA_WIDTH = 16;
   localparam int RMQ_FRAC_BITS  = 14;

   // diagonal element that leads the non-trace branch
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } rmq_axis_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rmq_qstat_type;

   // unsigned radicand width
   function automatic int rmq_rad_w(input int dw, input int fb);
      return ((dw > fb) ? dw : fb + 1) + 2;
   endfunction

   // width of the square root result
   function automatic int rmq_root_w(input int dw, input int fb);
      return (rmq_rad_w(dw, fb) + fb + 1) / 2;
   endfunction

   // width of the queued item
   function automatic int rmq_item_w(input int dw, input int fb);
      return 4 * (dw + 1) + 4 + rmq_rad_w(dw, fb);
   endfunction

endpackage

// ----- rtl/core/rmq_if.sv -----
// ----------------------------------------------------------------------------
// rmq_if
// matrix and quaternion channels, valid/ready
// ----------------------------------------------------------------------------
interface rmq_req_if
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m02;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;
   logic signed [DATA_WIDTH-1:0] m12;
   logic signed [DATA_WIDTH-1:0] m20;
   logic signed [DATA_WIDTH-1:0] m21;
   logic signed [DATA_WIDTH-1:0] m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface rmq_rsp_if
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] qw;
   logic signed [DATA_WIDTH-1:0] qx;
   logic signed [DATA_WIDTH-1:0] qy;
   logic signed [DATA_WIDTH-1:0] qz;
   logic                         degenerate;
   logic                         saturated;

   modport source (output valid, qw, qx, qy, qz, degenerate, saturated,
                   input ready);
   modport sink   (input valid, qw, qx, qy, qz, degenerate, saturated,
                   output ready);
endinterface

// ----- rtl/core/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Takes one 3x3 rotation matrix per cycle while the output is not stalled, and
// returns its quaternion. Every matrix is independent, so a new item is taken
// each cycle while earlier ones are in flight. The stages run in order: square
// root, numerator prep, divider and output register. The square root yields
// one root bit per stage and the four dividers one quotient bit per stage. A
// two-entry queue sits between the front and the pipeline, and the whole
// pipeline holds while a result waits at the output.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH,
   parameter int FRAC_BITS  = RMQ_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);

   localparam int IW = rmq_item_w(DATA_WIDTH, FRAC_BITS);

   logic          fr_valid, fr_ready;
   logic [IW-1:0] fr_data;
   logic          bk_valid, bk_ready;
   logic [IW-1:0] bk_data;
   rmq_qstat_type q_stat;

   rmq_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .req_ch     (req_ch),
      .item_valid (fr_valid),
      .item_ready (fr_ready),
      .item_data  (fr_data)
   );

   rmq_queue #(
      .WIDTH (IW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data),
      .stat       (q_stat)
   );

   rmq_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (bk_valid),
      .item_ready (bk_ready),
      .item_data  (bk_data),
      .rsp_ch     (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.degenerate) |->
         (rsp_ch.qw == 0 && rsp_ch.qx == 0 && rsp_ch.qy == 0 && rsp_ch.qz == 0
          && !rsp_ch.saturated))
      else $error("degenerate item with nonzero result");

   a_queue_stat: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

// ----- rtl/core/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front
// picks the branch and pivot, forms the radicand and the four lane numerators
// ----------------------------------------------------------------------------
module rmq_front
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH,
   parameter int FRAC_BITS  = RMQ_FRAC_BITS
) (
   rmq_req_if.sink                                 req_ch,
   output logic                                    item_valid,
   input  logic                                    item_ready,
   output logic [rmq_item_w(DATA_WIDTH, FRAC_BITS)-1:0] item_data
);

   localparam int DW = DATA_WIDTH;
   localparam int LW = DATA_WIDTH + 1;
   localparam int RW = rmq_rad_w(DATA_WIDTH, FRAC_BITS);
   localparam int EW = RW + 1;

   function automatic logic [LW-1:0] l_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
      return {a[DW-1], a} + {b[DW-1], b};
   endfunction

   function automatic logic [LW-1:0] l_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
      return {a[DW-1], a} - {b[DW-1], b};
   endfunction

   function automatic logic signed [EW-1:0] ext(input logic [DW-1:0] a);
      return {{(EW-DW){a[DW-1]}}, a};
   endfunction

   logic signed [EW-1:0] tr;
   logic signed [EW-1:0] one_s;
   logic signed [EW-1:0] rad_s;
   logic [RW-1:0]        rad_u;
   logic [LW-1:0]        d0, d1, d2, d3;
   logic [3:0]           half;
   rmq_axis_type         axis;

   assign item_valid   = req_ch.valid;
   assign req_ch.ready = item_ready;

   always_comb begin
      tr    = ext(req_ch.m00) + ext(req_ch.m11) + ext(req_ch.m22);
      one_s = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;
      axis  = (req_ch.m11 > req_ch.m00) ? AXIS_Y : AXIS_X;
      if (axis == AXIS_Y) begin
         if (req_ch.m22 > req_ch.m11) axis = AXIS_Z;
      end else begin
         if (req_ch.m22 > req_ch.m00) axis = AXIS_Z;
      end
      d0   = '0;
      d1   = '0;
      d2   = '0;
      d3   = '0;
      half = '0;
      if (tr > 0) begin
         rad_s = tr + one_s;
         half  = 4'b0001;
         d1    = l_sub(req_ch.m21, req_ch.m12);
         d2    = l_sub(req_ch.m02, req_ch.m20);
         d3    = l_sub(req_ch.m10, req_ch.m01);
      end else begin
         unique case (axis)
            AXIS_X: begin
               rad_s = ext(req_ch.m00) - (ext(req_ch.m11) + ext(req_ch.m22)) + one_s;
               half  = 4'b0010;
               d2    = l_add(req_ch.m10, req_ch.m01);
               d3    = l_add(req_ch.m20, req_ch.m02);
               d0    = l_sub(req_ch.m21, req_ch.m12);
            end
            AXIS_Y: begin
               rad_s = ext(req_ch.m11) - (ext(req_ch.m22) + ext(req_ch.m00)) + one_s;
               half  = 4'b0100;
               d3    = l_add(req_ch.m21, req_ch.m12);
               d1    = l_add(req_ch.m01, req_ch.m10);
               d0    = l_sub(req_ch.m02, req_ch.m20);
            end
            AXIS_Z: begin
               rad_s = ext(req_ch.m22) - (ext(req_ch.m00) + ext(req_ch.m11)) + one_s;
               half  = 4'b1000;
               d1    = l_add(req_ch.m02, req_ch.m20);
               d2    = l_add(req_ch.m12, req_ch.m21);
               d0    = l_sub(req_ch.m10, req_ch.m01);
            end
            default: begin
               rad_s = '0;
            end
         endcase
      end
      // negative radicand clamps to zero
      rad_u     = rad_s[EW-1] ? '0 : rad_s[RW-1:0];
      item_data = {rad_u, half, d3, d2, d1, d0};
   end

endmodule

// ----- rtl/core/rmq_queue.sv -----
// ----------------------------------------------------------------------------
// rmq_queue
// two-entry queue between the front and the arithmetic back end
// ----------------------------------------------------------------------------
module rmq_queue
   import rmq_pkg::*;
#(
   parameter int WIDTH = rmq_item_w(RMQ_DATA_WIDTH, RMQ_FRAC_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data,
   output rmq_qstat_type    stat
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/core/rmq_back.sv -----
// ----------------------------------------------------------------------------
// rmq_back
// pipelined square root, four pipelined dividers, rounding and saturation
// ----------------------------------------------------------------------------
module rmq_back
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = RMQ_DATA_WIDTH,
   parameter int FRAC_BITS  = RMQ_FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        item_valid,
   output logic                                        item_ready,
   input  logic [rmq_item_w(DATA_WIDTH, FRAC_BITS)-1:0] item_data,
   rmq_rsp_if.source                                   rsp_ch
);

   localparam int DW = DATA_WIDTH;
   localparam int LW = DATA_WIDTH + 1;
   localparam int RW = rmq_rad_w(DATA_WIDTH, FRAC_BITS);
   localparam int SW = rmq_root_w(DATA_WIDTH, FRAC_BITS);
   localparam int XW = 2 * SW;
   localparam int NW = DATA_WIDTH + FRAC_BITS + 1;
   localparam int PW = 4 * LW + 4;
   localparam logic [NW-1:0] POS_MAX = NW'((64'd1 << (DW - 1)) - 64'd1);
   localparam logic [NW-1:0] NEG_MAG = NW'(64'd1 << (DW - 1));

   logic adv;

   // square root, one root bit per stage
   logic          sq_vld_ff  [SW];
   logic [SW+1:0] sq_rem_ff  [SW];
   logic [SW-1:0] sq_root_ff [SW];
   logic [XW-1:0] sq_x_ff    [SW];
   logic [PW-1:0] sq_pay_ff  [SW];
   logic          sq_vld_src [SW];
   logic [SW+1:0] sq_rem_src [SW];
   logic [SW-1:0] sq_root_src[SW];
   logic [XW-1:0] sq_x_src   [SW];
   logic [PW-1:0] sq_pay_src [SW];
   logic [SW+1:0] sq_rem_in  [SW];
   logic [SW-1:0] sq_root_in [SW];

   assign sq_vld_src[0]  = item_valid;
   assign sq_rem_src[0]  = '0;
   assign sq_root_src[0] = '0;
   assign sq_x_src[0]    = XW'(item_data[PW +: RW]) << FRAC_BITS;
   assign sq_pay_src[0]  = item_data[PW-1:0];

   for (genvar s = 0; s < SW; s++) begin : g_sq
      logic [SW+3:0] cat;
      logic [SW+3:0] trial;

      if (s > 0) begin : g_link
         assign sq_vld_src[s]  = sq_vld_ff[s-1];
         assign sq_rem_src[s]  = sq_rem_ff[s-1];
         assign sq_root_src[s] = sq_root_ff[s-1];
         assign sq_x_src[s]    = sq_x_ff[s-1];
         assign sq_pay_src[s]  = sq_pay_ff[s-1];
      end

      always_comb begin
         cat   = {sq_rem_src[s], sq_x_src[s][XW-1:XW-2]};
         trial = (SW+4)'({sq_root_src[s], 2'b01});
         if (cat >= trial) begin
            sq_rem_in[s]  = (SW+2)'(cat - trial);
            sq_root_in[s] = {sq_root_src[s][SW-2:0], 1'b1};
         end else begin
            sq_rem_in[s]  = cat[SW+1:0];
            sq_root_in[s] = {sq_root_src[s][SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[s] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[s] <= sq_vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[s]  <= sq_rem_in[s];
            sq_root_ff[s] <= sq_root_in[s];
            sq_x_ff[s]    <= sq_x_src[s] << 2;
            sq_pay_ff[s]  <= sq_pay_src[s];
         end
      end
   end

   // numerator prep: |d| * 2^(frac-1) + s/2
   logic          pr_vld_ff;
   logic [SW-1:0] pr_s_ff;
   logic [3:0]    pr_half_ff;
   logic [3:0]    pr_neg_ff;
   logic [NW-1:0] pr_num_ff [4];
   logic [3:0]    pr_neg_in;
   logic [NW-1:0] pr_num_in [4];

   always_comb begin
      logic [LW-1:0] d;
      logic [LW-1:0] mag;
      for (int l = 0; l < 4; l++) begin
         d            = sq_pay_ff[SW-1][l*LW +: LW];
         pr_neg_in[l] = d[LW-1];
         mag          = d[LW-1] ? (LW'(0) - d) : d;
         pr_num_in[l] = (NW'(mag) << (FRAC_BITS - 1)) + NW'(sq_root_ff[SW-1] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (adv) begin
         pr_vld_ff <= sq_vld_ff[SW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_s_ff    <= sq_root_ff[SW-1];
         pr_half_ff <= sq_pay_ff[SW-1][4*LW +: 4];
         pr_neg_ff  <= pr_neg_in;
         for (int l = 0; l < 4; l++) pr_num_ff[l] <= pr_num_in[l];
      end
   end

   // restoring division, one quotient bit per stage in each lane
   logic          dv_vld_ff  [NW];
   logic [SW-1:0] dv_s_ff    [NW];
   logic [3:0]    dv_half_ff [NW];
   logic [3:0]    dv_neg_ff  [NW];
   logic [NW-1:0] dv_a_ff    [NW][4];
   logic [SW-1:0] dv_rem_ff  [NW][4];
   logic          dv_vld_src [NW];
   logic [SW-1:0] dv_s_src   [NW];
   logic [3:0]    dv_half_src[NW];
   logic [3:0]    dv_neg_src [NW];
   logic [NW-1:0] dv_a_src   [NW][4];
   logic [SW-1:0] dv_rem_src [NW][4];
   logic [NW-1:0] dv_a_in    [NW][4];
   logic [SW-1:0] dv_rem_in  [NW][4];

   assign dv_vld_src[0]  = pr_vld_ff;
   assign dv_s_src[0]    = pr_s_ff;
   assign dv_half_src[0] = pr_half_ff;
   assign dv_neg_src[0]  = pr_neg_ff;
   assign dv_a_src[0]    = pr_num_ff;
   assign dv_rem_src[0]  = '{default: '0};

   for (genvar s = 0; s < NW; s++) begin : g_dv
      if (s > 0) begin : g_link
         assign dv_vld_src[s]  = dv_vld_ff[s-1];
         assign dv_s_src[s]    = dv_s_ff[s-1];
         assign dv_half_src[s] = dv_half_ff[s-1];
         assign dv_neg_src[s]  = dv_neg_ff[s-1];
         assign dv_a_src[s]    = dv_a_ff[s-1];
         assign dv_rem_src[s]  = dv_rem_ff[s-1];
      end

      always_comb begin
         logic [SW:0] rt;
         for (int l = 0; l < 4; l++) begin
            rt = {dv_rem_src[s][l], dv_a_src[s][l][NW-1]};
            if (rt >= {1'b0, dv_s_src[s]}) begin
               dv_rem_in[s][l] = SW'(rt - {1'b0, dv_s_src[s]});
               dv_a_in[s][l]   = {dv_a_src[s][l][NW-2:0], 1'b1};
            end else begin
               dv_rem_in[s][l] = rt[SW-1:0];
               dv_a_in[s][l]   = {dv_a_src[s][l][NW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[s] <= dv_vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_s_ff[s]    <= dv_s_src[s];
            dv_half_ff[s] <= dv_half_src[s];
            dv_neg_ff[s]  <= dv_neg_src[s];
            dv_a_ff[s]    <= dv_a_in[s];
            dv_rem_ff[s]  <= dv_rem_in[s];
         end
      end
   end

   // sign, saturation and output register
   logic          rsp_vld_ff;
   logic [DW-1:0] q_ff [4];
   logic          degen_ff, sat_ff;
   logic [DW-1:0] q_in [4];
   logic          degen_in, sat_in;

   always_comb begin
      logic [NW-1:0] mag;
      logic [NW-1:0] neg_v;
      logic          neg;
      degen_in = (dv_s_ff[NW-1] == '0);
      sat_in   = 1'b0;
      for (int l = 0; l < 4; l++) begin
         neg = dv_neg_ff[NW-1][l];
         if (dv_half_ff[NW-1][l]) begin
            mag = NW'(dv_s_ff[NW-1] >> 1);
         end else if (degen_in) begin
            mag = '0;
         end else begin
            mag = dv_a_ff[NW-1][l];
         end
         neg_v = NW'(0) - mag;
         if (!neg && (mag > POS_MAX)) begin
            q_in[l] = {1'b0, {(DW-1){1'b1}}};
            sat_in  = 1'b1;
         end else if (neg && (mag > NEG_MAG)) begin
            q_in[l] = {1'b1, {(DW-1){1'b0}}};
            sat_in  = 1'b1;
         end else begin
            q_in[l] = neg ? neg_v[DW-1:0] : mag[DW-1:0];
         end
      end
   end

   assign adv        = !rsp_vld_ff || rsp_ch.ready;
   assign item_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff     <= q_in;
         degen_ff <= degen_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.qw         = q_ff[0];
   assign rsp_ch.qx         = q_ff[1];
   assign rsp_ch.qy         = q_ff[2];
   assign rsp_ch.qz         = q_ff[3];
   assign rsp_ch.degenerate = degen_ff;
   assign rsp_ch.saturated  = sat_ff;

endmodule

// ----- tb/tb_rmq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rmq_if
// interfaces are taken from the rtl; this file only carries the item type the
// testbench keeps for one matrix and one quaternion
// ----------------------------------------------------------------------------
package tb_rmq_pkg;
   import rmq_pkg::*;

   typedef logic signed [RMQ_DATA_WIDTH-1:0] elem_type;

   typedef struct {
      elem_type m[3][3];
   } matrix_type;

   typedef struct {
      elem_type qw;
      elem_type qx;
      elem_type qy;
      elem_type qz;
      logic     degenerate;
      logic     saturated;
   } quat_type;
endpackage

// ----- tb/tb_rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives matrices through the valid/ready input, computes each quaternion
// with an independent fixed-point predictor unless a directed row types it
// in, and compares every result in order. Directed rows cover identity, half
// turns, ties and saturating inputs; random rows mix proper rotations with raw noise.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
   import rmq_pkg::*;
   import tb_rmq_pkg::*;

   localparam int DW        = RMQ_DATA_WIDTH;
   localparam int FB        = RMQ_FRAC_BITS;
   localparam int LATENCY   = 60;
   localparam int WATCHDOG  = 20000;
   localparam int N_RANDOM  = 1200;
   localparam longint ONE   = 64'sd1 <<< FB;
   localparam longint HI    = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint LO    = -HI - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmq_req_if #(.DATA_WIDTH(DW)) req_ch ();
   rmq_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   quat_type expected_quats[$];
   quat_type directed_expect[$];
   int       mismatches = 0;
   int       checked = 0;
   int       sent = 0;
   int       idle_cycles = 0;
   int       n_degenerate = 0;
   int       n_saturated = 0;
   bit       stim_done = 0;
   bit       hold_long = 0;

   function automatic longint isqrt(longint x);
      longint r = 0;
      longint b = 64'sd1 <<< 60;
      while (b > x) b = b >>> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint half_over_root(longint d, longint s);
      longint num;
      longint mag;
      longint q;
      if (s == 0) return 0;
      num = d * (64'sd1 <<< (FB - 1));
      mag = (num < 0) ? -num : num;
      q = (mag + s / 2) / s;
      return (num < 0) ? -q : q;
   endfunction

   function automatic elem_type clip(longint v, ref logic hit);
      if (v > HI) begin
         hit = 1'b1;
         return elem_type'(HI);
      end
      if (v < LO) begin
         hit = 1'b1;
         return elem_type'(LO);
      end
      return elem_type'(v);
   endfunction

   function automatic quat_type matrix_to_quat(matrix_type a);
      longint m[3][3];
      longint q[3];
      longint w, tr, rad, s;
      int i, j, k;
      quat_type o;
      logic hit = 1'b0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = longint'(a.m[r][c]);
      tr = m[0][0] + m[1][1] + m[2][2];
      o.degenerate = 1'b0;
      if (tr > 0) begin
         s = isqrt((tr + ONE) <<< FB);
         w = s >>> 1;
         q[0] = half_over_root(m[2][1] - m[1][2], s);
         q[1] = half_over_root(m[0][2] - m[2][0], s);
         q[2] = half_over_root(m[1][0] - m[0][1], s);
      end else begin
         i = AXIS_X;
         if (m[1][1] > m[0][0]) i = AXIS_Y;
         if (m[2][2] > m[i][i]) i = AXIS_Z;
         j = (i == AXIS_Z) ? AXIS_X : i + 1;
         k = (j == AXIS_Z) ? AXIS_X : j + 1;
         rad = m[i][i] - (m[j][j] + m[k][k]) + ONE;
         if (rad < 0) rad = 0;
         s = isqrt(rad <<< FB);
         o.degenerate = (s == 0);
         q[i] = s >>> 1;
         q[j] = half_over_root(m[j][i] + m[i][j], s);
         q[k] = half_over_root(m[k][i] + m[i][k], s);
         w = half_over_root(m[k][j] - m[j][k], s);
      end
      o.qw = clip(w, hit);
      o.qx = clip(q[0], hit);
      o.qy = clip(q[1], hit);
      o.qz = clip(q[2], hit);
      o.saturated = hit;
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at result %0d: %s got %0d want %0d", checked, what, got, want);
   endtask

   // directed rows: nine elements, whether an expectation is typed in, and it
   typedef struct {
      longint   e[9];
      bit       typed;
      quat_type want;
   } row_type;

   row_type directed[$];

   function automatic matrix_type to_matrix(longint e[9]);
      matrix_type a;
      for (int n = 0; n < 9; n++) a.m[n / 3][n % 3] = elem_type'(e[n]);
      return a;
   endfunction

   function automatic quat_type typed_quat(longint w, longint x, longint y, longint z,
                                           logic dg, logic sat);
      quat_type o;
      o.qw = elem_type'(w); o.qx = elem_type'(x); o.qy = elem_type'(y);
      o.qz = elem_type'(z);
      o.degenerate = dg; o.saturated = sat;
      return o;
   endfunction

   task automatic add_row(longint e[9], bit typed = 0, quat_type want = '{default: 0});
      row_type r;
      r.e = e; r.typed = typed; r.want = want;
      directed.push_back(r);
   endtask

   // fixed-point rotation matrix from a random unit quaternion
   function automatic matrix_type random_rotation();
      real a, b, c, d, n;
      real f[9];
      matrix_type o;
      a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) begin a = 1.0; n = 1.0; end
      a /= n; b /= n; c /= n; d /= n;
      f = '{1-2*(c*c+d*d), 2*(b*c-a*d), 2*(b*d+a*c),
            2*(b*c+a*d), 1-2*(b*b+d*d), 2*(c*d-a*b),
            2*(b*d-a*c), 2*(c*d+a*b), 1-2*(b*b+c*c)};
      for (int n2 = 0; n2 < 9; n2++)
         o.m[n2 / 3][n2 % 3] =
            elem_type'($rtoi(f[n2] * ONE) + $signed($urandom_range(0, 4)) - 2);
      return o;
   endfunction

   function automatic matrix_type random_noise();
      matrix_type o;
      for (int n = 0; n < 9; n++) o.m[n / 3][n % 3] = elem_type'($urandom);
      return o;
   endfunction

   task automatic send(matrix_type a);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (hold_long || $urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.m00 <= a.m[0][0]; req_ch.m01 <= a.m[0][1]; req_ch.m02 <= a.m[0][2];
      req_ch.m10 <= a.m[1][0]; req_ch.m11 <= a.m[1][1]; req_ch.m12 <= a.m[1][2];
      req_ch.m20 <= a.m[2][0]; req_ch.m21 <= a.m[2][1]; req_ch.m22 <= a.m[2][2];
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   // accepted inputs are logged at the edge so prediction follows acceptance
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         matrix_type a;
         a.m = '{'{req_ch.m00, req_ch.m01, req_ch.m02},
                 '{req_ch.m10, req_ch.m11, req_ch.m12},
                 '{req_ch.m20, req_ch.m21, req_ch.m22}};
         if (directed_expect.size() > 0) expected_quats.push_back(directed_expect.pop_front());
         else expected_quats.push_back(matrix_to_quat(a));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         quat_type want;
         if (expected_quats.size() == 0) begin
            report("item with no matrix outstanding", rsp_ch.qw, 0);
         end else begin
            want = expected_quats.pop_front();
            if (rsp_ch.qw !== want.qw) report("qw", rsp_ch.qw, want.qw);
            if (rsp_ch.qx !== want.qx) report("qx", rsp_ch.qx, want.qx);
            if (rsp_ch.qy !== want.qy) report("qy", rsp_ch.qy, want.qy);
            if (rsp_ch.qz !== want.qz) report("qz", rsp_ch.qz, want.qz);
            if (rsp_ch.degenerate !== want.degenerate)
               report("degenerate", rsp_ch.degenerate, want.degenerate);
            if (rsp_ch.saturated !== want.saturated)
               report("saturated", rsp_ch.saturated, want.saturated);
            n_degenerate += want.degenerate;
            n_saturated += want.saturated;
         end
         checked++;
      end
   end

   // receiver: random stalls, and one long hold-off while the sender keeps going
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_ch.ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_long = 0;
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if (sent > 700 && sent < 900) gap = 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      longint s = 1 <<< (FB - 1);
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02} = '0;
      {req_ch.m10, req_ch.m11, req_ch.m12} = '0;
      {req_ch.m20, req_ch.m21, req_ch.m22} = '0;

      // identity and half turns about each axis
      add_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, typed_quat(ONE, 0, 0, 0, 0, 0));
      add_row('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1, typed_quat(0, ONE, 0, 0, 0, 0));
      add_row('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1, typed_quat(0, 0, ONE, 0, 0, 0));
      add_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1, typed_quat(0, 0, 0, ONE, 0, 0));
      // all zero: trace not positive, radicand one
      add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0});
      // diagonal ties keep the lower index
      add_row('{-s, 5, 7, 9, -s, 11, 13, 15, -s});
      add_row('{-ONE, 1, 2, 3, -s, 4, 5, 6, -s});
      // small positive trace, and a full-scale difference that clips qx
      add_row('{-ONE, 100, 200, 300, ONE, 400, 500, 600, ONE});
      add_row('{1, 0, 0, 0, 0, LO, 0, HI, 0});
      // field extremes
      add_row('{HI, HI, HI, HI, HI, HI, HI, HI, HI});
      add_row('{LO, LO, LO, LO, LO, LO, LO, LO, LO});
      add_row('{LO, HI, LO, HI, LO, HI, LO, HI, LO});
      add_row('{HI, LO, HI, LO, HI, LO, HI, LO, HI});
      add_row('{1, HI, LO, LO, 0, HI, HI, LO, 0});
      add_row('{-1, HI, LO, LO, -1, HI, HI, LO, -1});
      add_row('{LO, HI, HI, LO, LO, LO, HI, HI, 0});
      add_row('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
      add_row('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[n]) begin
         if (directed[n].typed) directed_expect.push_back(directed[n].want);
         else directed_expect.push_back(matrix_to_quat(to_matrix(directed[n].e)));
         send(to_matrix(directed[n].e));
      end
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 300) hold_long = 1;
         send(($urandom_range(0, 3) == 0) ? random_noise() : random_rotation());
      end
      req_ch.valid <= 1'b0;
      stim_done = 1;
      while (expected_quats.size() > 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      $display("%0d matrices sent, %0d quaternions checked", sent, checked);
      $display("%0d degenerate and %0d saturated results seen", n_degenerate, n_saturated);
      if (mismatches == 0 && expected_quats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
